### rtl/mkpt_pkg.sv
package mkpt_pkg;

  localparam int ROT_STEPS = 16;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ACCEL = 2'd1;
  localparam logic [1:0] REG_TURN  = 2'd2;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic               mode;
    logic [31:0]        accel;
    logic [31:0]        turn;
    logic [15:0]        d;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
  } pay_t;

  typedef struct packed {
    logic               vld;
    logic               neg;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    pay_t               p;
  } cordic_t;

  function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
    logic signed [32:0] r;
    unique case (i)
      5'd0:  r = 33'sd843314856;
      5'd1:  r = 33'sd497837829;
      5'd2:  r = 33'sd263043836;
      5'd3:  r = 33'sd133525158;
      5'd4:  r = 33'sd67021686;
      5'd5:  r = 33'sd33543515;
      5'd6:  r = 33'sd16775850;
      5'd7:  r = 33'sd8388437;
      5'd8:  r = 33'sd4194282;
      5'd9:  r = 33'sd2097149;
      5'd10: r = 33'sd1048575;
      5'd11: r = 33'sd524287;
      5'd12: r = 33'sd262143;
      5'd13: r = 33'sd131071;
      5'd14: r = 33'sd65535;
      5'd15: r = 33'sd32767;
      5'd16: r = 33'sd16383;
      5'd17: r = 33'sd8191;
      5'd18: r = 33'sd4095;
      5'd19: r = 33'sd2047;
      5'd20: r = 33'sd1023;
      5'd21: r = 33'sd511;
      5'd22: r = 33'sd255;
      5'd23: r = 33'sd127;
      5'd24: r = 33'sd63;
      5'd25: r = 33'sd31;
      5'd26: r = 33'sd15;
      5'd27: r = 33'sd7;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] satu32(input logic [63:0] v);
    logic signed [31:0] r;
    if (v > 64'd2147483647) r = 32'sh7fffffff;
    else r = signed'(v[31:0]);
    return r;
  endfunction

endpackage

### rtl/mkpt_if.sv
interface mkpt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading;
  logic signed [15:0] turn_rate;
  logic signed [15:0] vel_fwd;
  logic signed [15:0] vel_side;
  logic signed [15:0] acc_fwd;
  logic signed [15:0] acc_side;
  logic [15:0]        step_time;
  modport source (output valid, heading, turn_rate, vel_fwd, vel_side, acc_fwd, acc_side,
                  step_time, input ready);
  modport sink (input valid, heading, turn_rate, vel_fwd, vel_side, acc_fwd, acc_side,
                step_time, output ready);
endinterface

interface mkpt_out_if;
  logic               valid;
  logic               ready;
  logic               part;
  logic               last;
  logic               status;
  logic signed [31:0] value_0;
  logic signed [31:0] value_1;
  logic signed [31:0] value_2;
  logic signed [31:0] value_3;
  logic signed [31:0] value_4;
  logic signed [31:0] value_5;
  logic signed [31:0] value_6;
  logic signed [31:0] value_7;
  logic signed [31:0] value_8;
  modport source (output valid, part, last, status, value_0, value_1, value_2, value_3,
                  value_4, value_5, value_6, value_7, value_8, input ready);
  modport sink (input valid, part, last, status, value_0, value_1, value_2, value_3,
                value_4, value_5, value_6, value_7, value_8, output ready);
endinterface

### rtl/mkpt_cordic_cell.sv
module mkpt_cordic_cell
  import mkpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic [4:0] idx,
  input  cordic_t a,
  output cordic_t q
);

  cordic_t q_next;
  logic signed [32:0] dx, dy, at;

  always_comb begin
    dx = a.y >>> idx;
    dy = a.x >>> idx;
    at = atan_q30(idx);
    q_next = a;
    if (a.z >= 0) begin
      q_next.x = a.x - dx;
      q_next.y = a.y + dy;
      q_next.z = a.z - at;
    end else begin
      q_next.x = a.x + dx;
      q_next.y = a.y - dy;
      q_next.z = a.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

### rtl/mecanum_kalman_prediction_terms.sv
// Each request yields two results: the prediction terms (part 0), then the
// process-noise terms (part 1, status 1 and zero values in rotate-then-push
// mode). A request is taken in any cycle in which the output register is free
// or its second result is taken; the output channel moves two results per
// request. Sine and cosine come from a chain of ROT_STEPS CORDIC cells.
// Configuration is sampled with each request at the input stage.
module mecanum_kalman_prediction_terms
  import mkpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  mkpt_in_if.sink     in_ch,
  mkpt_out_if.source  out_ch
);

  logic        model_mode;
  logic [31:0] accel_noise, turn_noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_mode  <= 1'b0;
      accel_noise <= 32'd65536;
      turn_noise  <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  model_mode  <= cfg_data[0];
        REG_ACCEL: accel_noise <= cfg_data;
        REG_TURN:  turn_noise  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic ob_vld, ob_beat;

  assign adv = !ob_vld || (out_ch.ready && ob_beat);
  assign in_ch.ready = adv;

  // angle and fold
  logic               v0, v1;
  pay_t               pl0, pl1;
  logic signed [35:0] ang0, ang1, ang0_next, ang1_next, ang2;
  logic               neg2;
  cordic_t            chain [0:ROT_STEPS];
  cordic_t            init_next;
  logic signed [35:0] hd_ext, tr_ext, d_ext;

  always_comb begin
    hd_ext = 36'(in_ch.heading);
    tr_ext = 36'(in_ch.turn_rate);
    d_ext  = 36'(signed'({1'b0, in_ch.step_time}));
    ang0_next = (hd_ext <<< 18) + (model_mode ? (tr_ext * d_ext * 36'sd4) : 36'sd0);
    ang1_next = ang0;
    for (int k = 0; k < 3; k++) begin
      if (ang1_next > Q30_PI) ang1_next = ang1_next - Q30_TWO_PI;
    end
    for (int k = 0; k < 3; k++) begin
      if (ang1_next < -Q30_PI) ang1_next = ang1_next + Q30_TWO_PI;
    end
    ang2 = ang1;
    neg2 = 1'b0;
    if (ang1 > Q30_HALF_PI) begin
      ang2 = ang1 - Q30_PI;
      neg2 = 1'b1;
    end else if (ang1 < -Q30_HALF_PI) begin
      ang2 = ang1 + Q30_PI;
      neg2 = 1'b1;
    end
    init_next.vld = v1;
    init_next.neg = neg2;
    init_next.x   = CORDIC_GAIN;
    init_next.y   = '0;
    init_next.z   = ang2[32:0];
    init_next.p   = pl1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      v0 <= in_ch.valid;
      pl0.mode  <= model_mode;
      pl0.accel <= accel_noise;
      pl0.turn  <= turn_noise;
      pl0.d     <= in_ch.step_time;
      pl0.vx    <= in_ch.vel_fwd;
      pl0.vy    <= in_ch.vel_side;
      pl0.ax    <= in_ch.acc_fwd;
      pl0.ay    <= in_ch.acc_side;
      ang0 <= ang0_next;
      v1   <= v0;
      pl1  <= pl0;
      ang1 <= ang1_next;
      chain[0] <= init_next;
    end
  end

  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_cell
    mkpt_cordic_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .idx (5'(i)),
      .a   (chain[i]),
      .q   (chain[i+1])
    );
  end

  // term stages
  cordic_t co;
  logic v3, v4, v5, v6, v7, v8;
  pay_t pl3, pl4, pl5, pl6, pl7, pl8;
  logic signed [32:0] c3, s3;
  logic [24:0] d2_3, d2_4, d2_5;
  logic [29:0] p2_3, p2_4, p2_5, p2_6, p2_7;
  logic [29:0] p3_4, p3_5, p3_6, p3_7;
  logic [29:0] p4_5, p4_6, p4_7;
  logic [29:0] p5_6, p5_7, p6_7;
  logic signed [63:0] dc4, ds4, d2c4, d2s4;
  logic signed [35:0] axs4, vxs4, ayc4, vyc4;
  logic signed [36:0] bx5, by5;
  logic signed [31:0] pv0_5, pv1_5, pv2_5, pv3_5, pv4_5;
  logic signed [31:0] pv0_6, pv1_6, pv2_6, pv3_6, pv4_6, pv5_6, pv6_6;
  logic signed [31:0] pv0_7, pv1_7, pv2_7, pv3_7, pv4_7, pv5_7, pv6_7;
  logic signed [31:0] res0 [0:8];
  logic signed [31:0] res1 [0:8];
  logic [63:0] dd;
  logic signed [63:0] ds64, c64, s64, d2s64;

  function automatic logic [29:0] pstep(input logic [29:0] p, input logic [15:0] d);
    logic [63:0] t;
    t = 64'(p) * 64'(d) + 64'd32768;
    return t[45:16];
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [31:0] nz(input logic [31:0] a, input logic [29:0] p,
                                            input int sh);
    logic [63:0] t;
    t = 64'(a) * 64'(p);
    t = (t + (64'd1 << (sh - 1))) >> sh;
    return satu32(t);
  endfunction

  always_comb begin
    co  = chain[ROT_STEPS];
    dd  = 64'(co.p.d) * 64'(co.p.d);
    ds64  = 64'(signed'({1'b0, pl3.d}));
    c64   = 64'(c3);
    s64   = 64'(s3);
    d2s64 = 64'(signed'({1'b0, d2_3}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v3   <= co.vld;
      pl3  <= co.p;
      c3   <= co.neg ? -co.x : co.x;
      s3   <= co.neg ? -co.y : co.y;
      d2_3 <= 25'((dd + 64'd128) >> 8);
      p2_3 <= 30'((dd + 64'd2) >> 2);

      v4   <= v3;
      pl4  <= pl3;
      d2_4 <= d2_3;
      p2_4 <= p2_3;
      p3_4 <= pstep(p2_3, pl3.d);
      dc4  <= ds64 * c64;
      ds4  <= ds64 * s64;
      d2c4 <= d2s64 * c64;
      d2s4 <= d2s64 * s64;
      axs4 <= 36'(rnd(64'(pl3.ax) * s64 + 64'(pl3.ay) * c64, 14));
      vxs4 <= 36'(rnd(64'(pl3.vx) * s64 + 64'(pl3.vy) * c64, 14));
      ayc4 <= 36'(rnd(64'(pl3.ax) * c64 - 64'(pl3.ay) * s64, 14));
      vyc4 <= 36'(rnd(64'(pl3.vx) * c64 - 64'(pl3.vy) * s64, 14));

      v5    <= v4;
      pl5   <= pl4;
      d2_5  <= d2_4;
      p2_5  <= p2_4;
      p3_5  <= p3_4;
      p4_5  <= pstep(p3_4, pl4.d);
      pv0_5 <= 32'(rnd(dc4, 23));
      pv1_5 <= 32'(rnd(ds4, 23));
      pv2_5 <= 32'(rnd(d2c4, 32));
      pv3_5 <= 32'(rnd(d2s4, 32));
      pv4_5 <= signed'({9'd0, pl4.d, 7'd0});
      bx5   <= 37'(rnd(64'(signed'({1'b0, pl4.d})) * 64'(axs4), 17)) + 37'(vxs4);
      by5   <= 37'(rnd(64'(signed'({1'b0, pl4.d})) * 64'(ayc4), 17)) + 37'(vyc4);

      v6    <= v5;
      pl6   <= pl5;
      p2_6  <= p2_5;
      p3_6  <= p3_5;
      p4_6  <= p4_5;
      p5_6  <= pstep(p4_5, pl5.d);
      pv0_6 <= pv0_5;
      pv1_6 <= pv1_5;
      pv2_6 <= pv2_5;
      pv3_6 <= pv3_5;
      pv4_6 <= pv4_5;
      pv5_6 <= pl5.mode ?
               sat32(-rnd(64'(signed'({1'b0, d2_5})) * 64'(bx5), 28)) : 32'sd0;
      pv6_6 <= pl5.mode ?
               sat32(rnd(64'(signed'({1'b0, d2_5})) * 64'(by5), 28)) : 32'sd0;

      v7    <= v6;
      pl7   <= pl6;
      p2_7  <= p2_6;
      p3_7  <= p3_6;
      p4_7  <= p4_6;
      p5_7  <= p5_6;
      p6_7  <= pstep(p5_6, pl6.d);
      pv0_7 <= pv0_6;
      pv1_7 <= pv1_6;
      pv2_7 <= pv2_6;
      pv3_7 <= pv3_6;
      pv4_7 <= pv4_6;
      pv5_7 <= pv5_6;
      pv6_7 <= pv6_6;

      v8  <= v7;
      pl8 <= pl7;
      res0[0] <= pv0_7;
      res0[1] <= pv1_7;
      res0[2] <= pv2_7;
      res0[3] <= pv3_7;
      res0[4] <= pv4_7;
      res0[5] <= pv5_7;
      res0[6] <= pv6_7;
      res0[7] <= '0;
      res0[8] <= '0;
      if (pl7.mode) begin
        for (int k = 0; k < 9; k++) res1[k] <= '0;
      end else begin
        res1[0] <= nz(pl7.accel, p6_7, 25);
        res1[1] <= nz(pl7.accel, p5_7, 24);
        res1[2] <= nz(pl7.accel, p4_7, 24);
        res1[3] <= nz(pl7.accel, p4_7, 23);
        res1[4] <= nz(pl7.accel, p3_7, 23);
        res1[5] <= nz(pl7.accel, p2_7, 23);
        res1[6] <= nz(pl7.turn, p2_7, 23);
        res1[7] <= nz(pl7.turn, 30'({pl7.d, 14'd0}), 23);
        res1[8] <= satu32({25'd0, pl7.turn, 7'd0});
      end
    end
  end

  // output register: two results per request
  assign ob_vld = v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_beat <= 1'b0;
    end else if (adv) begin
      ob_beat <= 1'b0;
    end else if (out_ch.ready) begin
      ob_beat <= 1'b1;
    end
  end

  assign out_ch.valid   = ob_vld;
  assign out_ch.part    = ob_beat;
  assign out_ch.last    = ob_beat;
  assign out_ch.status  = ob_beat & pl8.mode;
  assign out_ch.value_0 = ob_beat ? res1[0] : res0[0];
  assign out_ch.value_1 = ob_beat ? res1[1] : res0[1];
  assign out_ch.value_2 = ob_beat ? res1[2] : res0[2];
  assign out_ch.value_3 = ob_beat ? res1[3] : res0[3];
  assign out_ch.value_4 = ob_beat ? res1[4] : res0[4];
  assign out_ch.value_5 = ob_beat ? res1[5] : res0[5];
  assign out_ch.value_6 = ob_beat ? res1[6] : res0[6];
  assign out_ch.value_7 = ob_beat ? res1[7] : res0[7];
  assign out_ch.value_8 = ob_beat ? res1[8] : res0[8];

endmodule
